// ===== src/matrix_multiply_core_defines.svh =====
// Assertion macros shared by the matrix multiply core.
// Each macro checks a property on the rising edge of clk while rst_n is high.
`ifndef MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_CORE_DEFINES_SVH

`define MMC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mm_pkg.sv =====
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = 4;
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = 40;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             zero;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last_elem;
    } mac_tag_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value);
        logic [DIM_W-1:0] result;
        result = (value > DIM_MAX) ? DIM_MAX : value;
        return result;
    endfunction

endpackage

`default_nettype wire

// ===== src/matrix_multiply_core.sv =====
// Channel   | Handshake                | Payload
// ----------+--------------------------+----------------------------------------------
// command   | start, busy              | opcode, row_index, col_index, element_value
// config    | cfg_write                | cfg_index, cfg_data
// result    | out_strobe               | out_row, out_col, out_value, last
//
// An element write leaves busy low, so writes can arrive every cycle while busy is low.
// A compute word keeps busy high while the loop runs and until its last step has left the s1 and s2 registers.
// The loop runs one multiply-accumulate per cycle, bound by the single read port of each store.
// Results leave one per completed element; the receiver has no way to stall them.
// Reset clears the control state and sets the dimension registers to their maximum;
// the stores are not cleared.
`default_nettype none

module matrix_multiply_core
    import mm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [OP_W-1:0]         opcode,
    input  wire logic [IDX_W-1:0]        row_index,
    input  wire logic [IDX_W-1:0]        col_index,
    input  wire logic signed [ELEM_W-1:0] element_value,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [DIM_W-1:0]        cfg_data,
    output logic                         out_strobe,
    output logic [IDX_W-1:0]             out_row,
    output logic [IDX_W-1:0]             out_col,
    output logic signed [ACC_W-1:0]      out_value,
    output logic                         last
);

`include "matrix_multiply_core_defines.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                     state_reg;
    logic                     state_next;
    logic [DIM_W-1:0]         rows_a_reg;
    logic [DIM_W-1:0]         inner_dim_reg;
    logic [DIM_W-1:0]         cols_b_reg;
    logic [IDX_W-1:0]         i_reg;
    logic [IDX_W-1:0]         i_next;
    logic [IDX_W-1:0]         j_reg;
    logic [IDX_W-1:0]         j_next;
    logic [IDX_W-1:0]         k_reg;
    logic [IDX_W-1:0]         k_next;
    mac_tag_t                 s1_reg;
    mac_tag_t                 s1_next;
    mac_tag_t                 s2_reg;
    logic signed [ELEM_W-1:0] rd_a_reg;
    logic signed [ELEM_W-1:0] rd_b_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     out_strobe_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic                     last_reg;

    logic signed [ELEM_W-1:0] mem_a [DEPTH];
    logic signed [ELEM_W-1:0] mem_b [DEPTH];

    logic              accept;
    logic              launch;
    logic              write_a;
    logic              write_b;
    logic              k_last;
    logic              j_last;
    logic              i_last;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    assign busy   = (state_reg == ST_RUN) || s1_reg.valid || s2_reg.valid;
    assign accept = start && !busy;
    assign launch = accept && (opcode == OP_COMPUTE)
                    && (rows_a_reg != '0) && (cols_b_reg != '0);
    assign write_a = accept && (opcode == OP_WRITE_A)
                     && ({1'b0, row_index} < rows_a_reg)
                     && ({1'b0, col_index} < inner_dim_reg);
    assign write_b = accept && (opcode == OP_WRITE_B)
                     && ({1'b0, row_index} < inner_dim_reg)
                     && ({1'b0, col_index} < cols_b_reg);

    assign k_last = (inner_dim_reg == '0) || (({1'b0, k_reg} + 4'd1) == inner_dim_reg);
    assign j_last = ({1'b0, j_reg} + 4'd1) == cols_b_reg;
    assign i_last = ({1'b0, i_reg} + 4'd1) == rows_a_reg;
    assign addr_a = {i_reg, k_reg};
    assign addr_b = {k_reg, j_reg};

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (!k_last)
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    k_next = '0;
                    if (!j_last)
                    begin
                        j_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s1_next.valid     = (state_reg == ST_RUN);
        s1_next.first     = (k_reg == '0);
        s1_next.last_k    = k_last;
        s1_next.zero      = (inner_dim_reg == '0);
        s1_next.row       = i_reg;
        s1_next.col       = j_reg;
        s1_next.last_elem = i_last && j_last;
    end

    assign prod_next = s1_reg.zero ? $signed({PROD_W{1'b0}}) : rd_a_reg * rd_b_reg;
    assign acc_next  = s2_reg.first ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rows_a_reg     <= DIM_MAX;
            inner_dim_reg  <= DIM_MAX;
            cols_b_reg     <= DIM_MAX;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            out_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            s1_reg         <= s1_next;
            s2_reg         <= s1_reg;
            out_strobe_reg <= s2_reg.valid && s2_reg.last_k;
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_ROWS_A:    rows_a_reg    <= clamp_dim(cfg_data);
                    CFG_INNER_DIM: inner_dim_reg <= clamp_dim(cfg_data);
                    CFG_COLS_B:    cols_b_reg    <= clamp_dim(cfg_data);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_a)
        begin
            mem_a[{row_index, col_index}] <= element_value;
        end
        if (write_b)
        begin
            mem_b[{row_index, col_index}] <= element_value;
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
        prod_reg <= prod_next;
        if (s2_reg.valid)
        begin
            acc_reg <= acc_next;
        end
        if (s2_reg.valid && s2_reg.last_k)
        begin
            out_row_reg   <= s2_reg.row;
            out_col_reg   <= s2_reg.col;
            out_value_reg <= acc_next;
            last_reg      <= s2_reg.last_elem;
        end
    end

    assign out_strobe = out_strobe_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign out_value  = out_value_reg;
    assign last       = last_reg;

    `MMC_ASSERT_SAME(a_last_drains, out_strobe_reg && last_reg, !busy,
        "Last result word shown while the core is still busy.")
    `MMC_ASSERT_NEXT(a_launch_busy, launch, busy,
        "Compute word accepted but the core did not go busy.")
    `MMC_ASSERT_NEXT(a_finish_emits, s2_reg.valid && s2_reg.last_k, out_strobe_reg,
        "Finished sum did not produce a result word.")
    `MMC_ASSERT_SAME(a_result_in_size, out_strobe_reg,
        ({1'b0, out_row_reg} < rows_a_reg) && ({1'b0, out_col_reg} < cols_b_reg),
        "Result word lies outside the configured size.")

endmodule

`default_nettype wire

// ===== tb/matrix_multiply_core_tb.sv =====
`timescale 1ns / 100ps

module matrix_multiply_core_tb;
    import mm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_WORDS   = 150;

    typedef struct {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] value;
        logic                    last;
    } c_elem_t;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     start         = 1'b0;
    logic [OP_W-1:0]          opcode        = '0;
    logic [IDX_W-1:0]         row_index     = '0;
    logic [IDX_W-1:0]         col_index     = '0;
    logic signed [ELEM_W-1:0] element_value = '0;
    logic                     cfg_write     = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index     = '0;
    logic [DIM_W-1:0]         cfg_data      = '0;
    logic                     busy;
    logic                     out_strobe;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [ACC_W-1:0]  out_value;
    logic                     last;

    c_elem_t expected_c[$];
    c_elem_t oldest;

    logic signed [ELEM_W-1:0] a_store [DEPTH];
    logic signed [ELEM_W-1:0] b_store [DEPTH];
    bit a_loaded [DEPTH];
    bit b_loaded [DEPTH];
    int dim_rows  = MAX_DIM;
    int dim_inner = MAX_DIM;
    int dim_cols  = MAX_DIM;

    bit gaps_on = 1'b1;
    int mismatches;
    int idle_cycles;
    int words_in;
    int results_in;
    int products;
    int reg_writes;
    int useful_words;

    matrix_multiply_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_strobe    (out_strobe),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_product();
        c_elem_t e;
        longint acc;
        for (int i = 0; i < dim_rows; i++)
        begin
            for (int j = 0; j < dim_cols; j++)
            begin
                acc = 0;
                for (int k = 0; k < dim_inner; k++)
                begin
                    acc += longint'(a_store[i * MAX_DIM + k])
                           * longint'(b_store[k * MAX_DIM + j]);
                end
                e.row   = IDX_W'(i);
                e.col   = IDX_W'(j);
                e.value = acc[ACC_W-1:0];
                e.last  = (i == dim_rows - 1) && (j == dim_cols - 1);
                expected_c.insert(expected_c.size(), e);
            end
        end
        products++;
    endtask

    task automatic apply_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col,
                              input logic signed [ELEM_W-1:0] value);
        case (op)
            OP_WRITE_A:
            begin
                if (row < dim_rows && col < dim_inner)
                begin
                    a_store[row * MAX_DIM + col]  = value;
                    a_loaded[row * MAX_DIM + col] = 1'b1;
                    useful_words++;
                end
            end
            OP_WRITE_B:
            begin
                if (row < dim_inner && col < dim_cols)
                begin
                    b_store[row * MAX_DIM + col]  = value;
                    b_loaded[row * MAX_DIM + col] = 1'b1;
                    useful_words++;
                end
            end
            OP_COMPUTE:
            begin
                predict_product();
                useful_words++;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic scramble_fields();
        opcode        = OP_W'($urandom_range(0, 3));
        row_index     = IDX_W'($urandom_range(0, 7));
        col_index     = IDX_W'($urandom_range(0, 7));
        element_value = ELEM_W'($urandom);
        cfg_index     = CFG_IDX_W'($urandom_range(0, 3));
        cfg_data      = DIM_W'($urandom_range(0, 15));
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        start = 1'b0;
        scramble_fields();
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [ELEM_W-1:0] value);
        if (gaps_on && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 6));
        @(negedge clk);
        start         = 1'b1;
        opcode        = op;
        row_index     = row;
        col_index     = col;
        element_value = value;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_in++;
        apply_word(op, row, col, value);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        start = 1'b0;
        scramble_fields();
        while (expected_c.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        int dim;
        dim = (data > MAX_DIM) ? MAX_DIM : int'(data);
        @(negedge clk);
        start     = 1'b0;
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        scramble_fields();
        reg_writes++;
        case (idx)
            CFG_ROWS_A:    dim_rows  = dim;
            CFG_INNER_DIM: dim_inner = dim;
            CFG_COLS_B:    dim_cols  = dim;
            default:
            begin
            end
        endcase
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sh7FFF;
        else if (r == 1)
            return 16'sh8000;
        else if (r == 2)
            return '0;
        return ELEM_W'($urandom);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return DIM_W'(MAX_DIM);
        else if (r == 2)
            return DIM_W'($urandom_range(MAX_DIM + 1, 15));
        return DIM_W'($urandom_range(1, 4));
    endfunction

    task automatic fill_unwritten();
        for (int i = 0; i < dim_rows; i++)
        begin
            for (int k = 0; k < dim_inner; k++)
            begin
                if (!a_loaded[i * MAX_DIM + k])
                    send_word(OP_WRITE_A, IDX_W'(i), IDX_W'(k), pick_value());
            end
        end
        for (int k = 0; k < dim_inner; k++)
        begin
            for (int j = 0; j < dim_cols; j++)
            begin
                if (!b_loaded[k * MAX_DIM + j])
                    send_word(OP_WRITE_B, IDX_W'(k), IDX_W'(j), pick_value());
            end
        end
    endtask

    task automatic random_word();
        int r;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        r = $urandom_range(0, 19);
        if (r < 8 && dim_rows > 0 && dim_inner > 0)
        begin
            row = IDX_W'($urandom_range(0, dim_rows - 1));
            col = IDX_W'($urandom_range(0, dim_inner - 1));
            send_word(OP_WRITE_A, row, col, pick_value());
        end
        else if (r < 16 && dim_inner > 0 && dim_cols > 0)
        begin
            row = IDX_W'($urandom_range(0, dim_inner - 1));
            col = IDX_W'($urandom_range(0, dim_cols - 1));
            send_word(OP_WRITE_B, row, col, pick_value());
        end
        else if (r < 19)
        begin
            send_word($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A,
                      IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)), pick_value());
        end
        else
        begin
            send_word(OP_UNUSED, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                      pick_value());
        end
    endtask

    task automatic test_corner_values();
        write_reg(CFG_ROWS_A, 4'd2);
        write_reg(CFG_INNER_DIM, 4'd2);
        write_reg(CFG_COLS_B, 4'd2);
        send_word(OP_WRITE_A, 3'd0, 3'd0, 16'sh8000);
        send_word(OP_WRITE_A, 3'd0, 3'd1, 16'sh8000);
        send_word(OP_WRITE_A, 3'd1, 3'd0, 16'sh7FFF);
        send_word(OP_WRITE_A, 3'd1, 3'd1, 16'sh0001);
        send_word(OP_WRITE_B, 3'd0, 3'd0, 16'sh8000);
        send_word(OP_WRITE_B, 3'd0, 3'd1, 16'sh7FFF);
        send_word(OP_WRITE_B, 3'd1, 3'd0, 16'sh8000);
        send_word(OP_WRITE_B, 3'd1, 3'd1, 16'shFFFF);
        // Writes beyond the configured size and the spare opcode must leave the stores alone.
        send_word(OP_WRITE_A, 3'd7, 3'd7, 16'sh7FFF);
        send_word(OP_WRITE_A, 3'd0, 3'd5, 16'sh1234);
        send_word(OP_WRITE_B, 3'd2, 3'd0, 16'sh4321);
        send_word(OP_UNUSED, 3'd1, 3'd1, 16'sh5555);
        send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        send_word(OP_COMPUTE, 3'd7, 3'd7, 16'shFFFF);
        wait_idle();
    endtask

    task automatic test_full_size();
        write_reg(CFG_ROWS_A, 4'd15);
        write_reg(CFG_INNER_DIM, 4'd9);
        write_reg(CFG_COLS_B, 4'd8);
        send_word(OP_WRITE_A, 3'd7, 3'd7, 16'sh7FFF);
        send_word(OP_WRITE_B, 3'd7, 3'd7, 16'sh8000);
        send_word(OP_WRITE_A, 3'd7, 3'd0, 16'sh8000);
        send_word(OP_WRITE_B, 3'd0, 3'd7, 16'sh8000);
        fill_unwritten();
        send_word(OP_COMPUTE, 3'd5, 3'd2, 16'sh0F0F);
        wait_idle();
    endtask

    task automatic test_zero_dims();
        write_reg(CFG_ROWS_A, 4'd0);
        send_word(OP_WRITE_A, 3'd0, 3'd0, 16'sh2222);
        send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
        write_reg(CFG_ROWS_A, 4'd3);
        write_reg(CFG_COLS_B, 4'd0);
        send_word(OP_WRITE_B, 3'd0, 3'd0, 16'sh3333);
        send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
        write_reg(CFG_COLS_B, 4'd2);
        write_reg(CFG_INNER_DIM, 4'd0);
        send_word(OP_WRITE_A, 3'd0, 3'd0, 16'sh4444);
        send_word(OP_WRITE_B, 3'd0, 3'd0, 16'sh5555);
        send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
        write_reg(CFG_SPARE, DIM_W'($urandom_range(0, 15)));
        send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
    endtask

    task automatic test_resize();
        write_reg(CFG_ROWS_A, 4'd8);
        write_reg(CFG_INNER_DIM, 4'd8);
        write_reg(CFG_COLS_B, 4'd8);
        send_word(OP_WRITE_A, 3'd1, 3'd4, pick_value());
        send_word(OP_WRITE_B, 3'd4, 3'd1, pick_value());
        wait_idle();
        write_reg(CFG_ROWS_A, 4'd3);
        write_reg(CFG_INNER_DIM, 4'd5);
        write_reg(CFG_COLS_B, 4'd2);
        fill_unwritten();
        send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
        write_reg(CFG_ROWS_A, 4'd5);
        write_reg(CFG_INNER_DIM, 4'd1);
        write_reg(CFG_COLS_B, 4'd7);
        fill_unwritten();
        send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int target;
        int burst;
        target = useful_words + RANDOM_WORDS;
        while (useful_words < target)
        begin
            wait_idle();
            if (target - useful_words < RANDOM_WORDS / 5)
                gaps_on = 1'b0;
            else
                gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_ROWS_A, pick_dim());
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_INNER_DIM, pick_dim());
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_COLS_B, pick_dim());
            burst = $urandom_range(2, 10);
            repeat (burst) random_word();
            fill_unwritten();
            send_word(OP_COMPUTE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                      ELEM_W'($urandom));
            // New words may queue up behind a product that is still running.
            if ($urandom_range(0, 2) == 0)
            begin
                burst = $urandom_range(1, 4);
                repeat (burst) random_word();
                fill_unwritten();
                send_word(OP_COMPUTE, 3'd0, 3'd0, 16'sh0000);
            end
        end
        gaps_on = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_strobe)
        begin
            results_in++;
            if (expected_c.size() == 0)
            begin
                if (mismatches < 10)
                    $display("Unexpected result word: row %0d col %0d value %h last %b",
                             out_row, out_col, out_value, last);
                mismatches++;
            end
            else
            begin
                oldest = expected_c.pop_front();
                if (out_row !== oldest.row || out_col !== oldest.col
                    || out_value !== oldest.value || last !== oldest.last)
                begin
                    if (mismatches < 10)
                        $display({"Result mismatch: expected row %0d col %0d value %h last %b,",
                                  " got row %0d col %0d value %h last %b"},
                                 oldest.row, oldest.col, oldest.value, oldest.last,
                                 out_row, out_col, out_value, last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || out_strobe || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
                     idle_cycles, expected_c.size());
            $display("matrix_multiply_core regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_corner_values();
        test_full_size();
        test_zero_dims();
        test_resize();
        test_random_traffic();
        wait_idle();
        $display("Sent %0d command words and %0d register writes, started %0d products.",
                 words_in, reg_writes, products);
        $display("Checked %0d result words, %0d mismatches, %0d results never seen.",
                 results_in, mismatches, expected_c.size());
        if (mismatches == 0 && expected_c.size() == 0)
            $display("matrix_multiply_core regression: pass");
        else
            $display("matrix_multiply_core regression: fail");
        $finish;
    end

endmodule
